[rtl/checked_int64_alu_defines.svh]
// Assertion macros used by the port-level checker file.
`ifndef CHECKED_INT64_ALU_DEFINES_SVH
`define CHECKED_INT64_ALU_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define CIA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define CIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/cia_pkg.sv]
package cia_pkg;

    localparam int unsigned WORD_W     = 64;
    localparam int unsigned OP_W       = 4;
    localparam int unsigned ST_W       = 2;
    // One quotient bit and one multiplier bit per cell.
    localparam int unsigned NUM_STAGES = WORD_W;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_FDIV = 4'd3,
        OP_FMOD = 4'd4,
        OP_QUOT = 4'd5,
        OP_REM  = 4'd6,
        OP_EQ   = 4'd7,
        OP_LT   = 4'd8
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

    // Context riding with an item down the chain.
    typedef struct packed {
        logic              vld;
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic              neg_a;
        logic              neg_b;
        logic [WORD_W-1:0] mag_b;
        logic [WORD_W-1:0] dvd;     // dividend bits still to shift in
        logic [WORD_W:0]   rem;     // partial remainder
        logic [WORD_W-1:0] quo;     // quotient bits so far
        logic [2*WORD_W-1:0] prod;  // product accumulator (magnitudes)
    } cell_data_t;

endpackage

[rtl/cia_cell.sv]
// One chain cell: one restoring divide step and one 1-bit multiply step.
module cia_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [5:0]          step_idx,
    input  cia_pkg::cell_data_t din,
    output cia_pkg::cell_data_t dout
);
    import cia_pkg::*;

    cell_data_t         data_next;
    cell_data_t         data_reg;
    logic               vld_reg;
    logic [WORD_W:0]    trial;
    logic [WORD_W:0]    shifted;
    logic [WORD_W-1:0]  mag_a;

    always_comb
    begin
        data_next = din;
        shifted   = {din.rem[WORD_W-1:0], din.dvd[WORD_W-1]};
        trial     = shifted - {1'b0, din.mag_b};
        data_next.dvd = {din.dvd[WORD_W-2:0], 1'b0};
        if (!trial[WORD_W])
        begin
            data_next.rem = trial;
            data_next.quo = {din.quo[WORD_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem = shifted;
            data_next.quo = {din.quo[WORD_W-2:0], 1'b0};
        end
        mag_a = din.neg_a ? (~din.a + 1'b1) : din.a;
        if (mag_a[step_idx])
            data_next.prod = din.prod
                + ({{WORD_W{1'b0}}, din.mag_b} << step_idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (advance)
            vld_reg <= din.vld;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            data_reg <= data_next;
    end

    always_comb
    begin
        dout     = data_reg;
        dout.vld = vld_reg;
    end
endmodule

[rtl/cia_finish.sv]
// Final result formation from the chain's last cell.
module cia_finish
(
    input  cia_pkg::cell_data_t          din,
    output logic [cia_pkg::WORD_W-1:0]   res,
    output logic [cia_pkg::ST_W-1:0]     st
);
    import cia_pkg::*;

    localparam logic [WORD_W-1:0] INT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    logic [WORD_W-1:0]   sum;
    logic [WORD_W-1:0]   diff;
    logic [WORD_W-1:0]   q;
    logic [WORD_W-1:0]   r;
    logic [2*WORD_W-1:0] prod_s;
    logic                div0;
    logic                min_neg1;
    logic                adjust;
    logic                mul_ovf;

    always_comb
    begin
        sum   = din.a + din.b;
        diff  = din.a - din.b;
        q     = (din.neg_a ^ din.neg_b) ? (~din.quo + 1'b1) : din.quo;
        r     = din.neg_a ? (~din.rem[WORD_W-1:0] + 1'b1) : din.rem[WORD_W-1:0];
        prod_s = (din.neg_a ^ din.neg_b) ? (~din.prod + 1'b1) : din.prod;
        mul_ovf = (prod_s[2*WORD_W-1:WORD_W-1] != {(WORD_W+1){1'b0}})
               && (prod_s[2*WORD_W-1:WORD_W-1] != {(WORD_W+1){1'b1}});
        div0     = (din.b == '0);
        min_neg1 = (din.a == INT_MIN) && (din.b == '1);
        adjust   = (r != '0) && (r[WORD_W-1] != din.b[WORD_W-1]);
        res = '0;
        st  = ST_OK;
        unique case (din.op)
            OP_ADD:
            begin
                res = sum;
                if ((din.a[WORD_W-1] == din.b[WORD_W-1]) && (sum[WORD_W-1] != din.a[WORD_W-1]))
                    st = ST_OVF;
            end
            OP_SUB:
            begin
                res = diff;
                if ((din.a[WORD_W-1] != din.b[WORD_W-1]) && (diff[WORD_W-1] != din.a[WORD_W-1]))
                    st = ST_OVF;
            end
            OP_MUL:
            begin
                res = prod_s[WORD_W-1:0];
                if (mul_ovf)
                    st = ST_OVF;
            end
            OP_FDIV, OP_FMOD, OP_QUOT, OP_REM:
            begin
                priority if (div0)
                    st = ST_DIV0;
                else if (min_neg1)
                begin
                    if (din.op == OP_FDIV || din.op == OP_QUOT)
                    begin
                        res = INT_MIN;
                        st  = ST_OVF;
                    end
                end
                else
                begin
                    unique case (din.op)
                        OP_FDIV: res = adjust ? q - 1'b1 : q;
                        OP_FMOD: res = adjust ? r + din.b : r;
                        OP_QUOT: res = q;
                        default: res = r;
                    endcase
                end
            end
            OP_EQ: res = {{(WORD_W-1){1'b0}}, din.a == din.b};
            OP_LT: res = {{(WORD_W-1){1'b0}}, $signed(din.a) < $signed(din.b)};
            default: ;
        endcase
    end
endmodule

[rtl/checked_int64_alu.sv]
// Channel | Direction | Handshake     | Payload
// in      | input     | valid / stall | op, operand_a, operand_b
// out     | output    | valid / stall | result, status
//
// Throughput: one transfer per cycle on each side while the output is not stalled.
// Path: the chain of 64 cells (one quotient bit and
// one multiplier bit per cell), then the output register.
// Reset clears every valid flag in the chain and the output valid.
// An output stall while a valid result is held freezes the whole chain; the input stall follows it.
module checked_int64_alu
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [cia_pkg::OP_W-1:0]           op,
    input  logic signed [cia_pkg::WORD_W-1:0]  operand_a,
    input  logic signed [cia_pkg::WORD_W-1:0]  operand_b,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [cia_pkg::WORD_W-1:0]  result,
    output logic [cia_pkg::ST_W-1:0]           status
);
    import cia_pkg::*;

    cell_data_t         entry;
    cell_data_t         chain [NUM_STAGES+1];
    logic               advance;
    logic [WORD_W-1:0]  fin_res;
    logic [ST_W-1:0]    fin_st;
    logic               out_valid_reg;
    logic [WORD_W-1:0]  result_reg;
    logic [ST_W-1:0]    status_reg;

    // Whole chain moves unless a finished result sits in the output stalled.
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    // Entry: take magnitudes for the shared unsigned divide/multiply steps.
    always_comb
    begin
        entry       = '0;
        entry.vld   = in_valid;
        entry.op    = op;
        entry.a     = operand_a;
        entry.b     = operand_b;
        entry.neg_a = operand_a[WORD_W-1];
        entry.neg_b = operand_b[WORD_W-1];
        entry.mag_b = operand_b[WORD_W-1] ? (~operand_b + 1'b1) : operand_b;
        entry.dvd   = operand_a[WORD_W-1] ? (~operand_a + 1'b1) : operand_a;
    end

    assign chain[0] = entry;

    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_cell
        cia_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .step_idx (6'(i)),
            .din      (chain[i]),
            .dout     (chain[i+1])
        );
    end

    cia_finish u_finish
    (
        .din (chain[NUM_STAGES]),
        .res (fin_res),
        .st  (fin_st)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= chain[NUM_STAGES].vld;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= fin_res;
            status_reg <= fin_st;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign status    = status_reg;
endmodule

[rtl/cia_checker.sv]
`include "checked_int64_alu_defines.svh"
// Port-level checks on the ALU.
module cia_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] result,
    input logic [1:0]  status
);
    import cia_pkg::*;

    `CIA_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, status == ST_OK || status == ST_OVF || status == ST_DIV0)
    `CIA_ASSERT_IMP(a_div0_zero, clk, rst_n, out_valid && status == ST_DIV0, result == 64'd0)
    `CIA_ASSERT_IMP(a_stall_follows, clk, rst_n, out_valid && out_stall, in_stall)
    `CIA_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(result))
endmodule

bind checked_int64_alu cia_checker u_cia_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result),
    .status    (status)
);

[tb/checked_int64_alu_tb.sv]
module checked_int64_alu_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cia_pkg::*;

    localparam longint MIN64 = 64'sh8000_0000_0000_0000;
    localparam longint MAX64 = 64'sh7fff_ffff_ffff_ffff;
    // Chain depth plus output register; used for the drain after the last result.
    localparam int PIPE_LAT = 65;

    typedef struct packed {
        logic [63:0] res;
        logic [1:0]  st;
    } alu_out_t;

    // Predicts each ALU result and holds the outstanding ones in order.
    class alu_scoreboard;
        alu_out_t pending[$];
        int       errors = 0;

        function alu_out_t compute(logic [3:0] opc, longint a, longint b);
            alu_out_t r;
            longint   q;
            longint   m;
            logic     fix;
            r.res = '0;
            r.st  = ST_OK;
            case (opc)
                OP_ADD:
                begin
                    r.res = a + b;
                    if (a[63] == b[63] && r.res[63] != a[63]) r.st = ST_OVF;
                end
                OP_SUB:
                begin
                    r.res = a - b;
                    if (a[63] != b[63] && r.res[63] != a[63]) r.st = ST_OVF;
                end
                OP_MUL:
                begin
                    logic signed [127:0] full;
                    full = 128'(signed'(a)) * 128'(signed'(b));
                    r.res = full[63:0];
                    // Overflow when the upper half is not the sign extension.
                    if (full[127:63] != {65{full[63]}}) r.st = ST_OVF;
                end
                OP_FDIV, OP_FMOD, OP_QUOT, OP_REM:
                begin
                    if (b == 0)
                        r.st = ST_DIV0;
                    else if (a == MIN64 && b == -1)
                    begin
                        // Only the quotient forms overflow; the remainder is zero.
                        if (opc == OP_FDIV || opc == OP_QUOT)
                        begin
                            r.res = MIN64;
                            r.st  = ST_OVF;
                        end
                    end
                    else
                    begin
                        q = a / b;
                        m = a % b;
                        fix = (m != 0) && ((m < 0) != (b < 0));
                        case (opc)
                            OP_FDIV: r.res = fix ? q - 1 : q;
                            OP_FMOD: r.res = fix ? m + b : m;
                            OP_QUOT: r.res = q;
                            default: r.res = m;
                        endcase
                    end
                end
                OP_EQ: r.res = (a == b) ? 64'd1 : 64'd0;
                OP_LT: r.res = (a < b) ? 64'd1 : 64'd0;
                default: ;
            endcase
            return r;
        endfunction

        function void note_input(logic [3:0] opc, longint a, longint b);
            pending.push_back(compute(opc, a, b));
        endfunction

        function void check_result(logic [63:0] res, logic [1:0] st);
            alu_out_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h status %0d", $time, res, st);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (res !== e.res)
            begin
                $display("%0t: result mismatch expected %h actual %h", $time, e.res, res);
                errors++;
            end
            if (st !== e.st)
            begin
                $display("%0t: status mismatch expected %0d actual %0d", $time, e.st, st);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [3:0]         op = '0;
    logic signed [63:0] operand_a = '0;
    logic signed [63:0] operand_b = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [63:0] result;
    logic [1:0]         status;

    alu_scoreboard sb = new();
    bit            stim_done = 1'b0;
    int            stall_mode = 0;

    checked_int64_alu u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result),
        .status    (status)
    );

    always #6 clk = ~clk;

    // Rising edge: note accepted input transfers and check output transfers.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall) sb.note_input(op, operand_a, operand_b);
            if (out_valid && !out_stall) sb.check_result(result, status);
        end
    end

    // Receiver backpressure: the mode changes every so often, covering
    // no stall, light random stall, heavy random stall and long holds.
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 9) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 15) != 0);
        endcase
    end

    // Drives one transfer and holds it until accepted; valid stays high
    // on return so back-to-back transfers need no lowering.
    task automatic send(input logic [3:0] opc, input longint a, input longint b);
        op        <= opc;
        operand_a <= a;
        operand_b <= b;
        in_valid  <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic idle(input int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Operand mix: corner values, small numbers, or shifted or full random words.
    function automatic longint pick_operand();
        case ($urandom_range(0, 9))
            0: return MIN64;
            1: return MAX64;
            2: return -1;
            3: return 0;
            4: return 1;
            5, 6: return longint'($urandom_range(0, 200)) - 100;
            7: return {$urandom, $urandom} >>> $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        longint corner[6];
        int     burst;
        corner = '{MIN64, MAX64, -1, 0, 1, -7};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: every op over a corner pairing, plus the division
        // special cases (divide by zero, minimum by minus one), overflow cases, unused ops.
        for (int o = 0; o <= 8; o++)
            send(4'(o), corner[o % 6], corner[(o + 2) % 6]);
        send(OP_FDIV, MIN64, -1);
        send(OP_QUOT, MIN64, -1);
        send(OP_FMOD, MIN64, -1);
        send(OP_REM,  MIN64, -1);
        send(OP_FDIV, 5, 0);
        send(OP_REM,  -5, 0);
        send(OP_FDIV, -7, 2);
        send(OP_FMOD, 7, -2);
        send(OP_MUL,  MAX64, 2);
        send(OP_ADD,  MAX64, 1);
        send(OP_SUB,  MIN64, 1);
        send(OP_LT,   MIN64, MAX64);
        send(4'd15,   MAX64, MIN64);
        send(4'd9,    -1, -1);

        // Let everything drain once before the random phase.
        idle(1);
        wait (sb.pending.size() == 0);
        @(negedge clk);

        for (int n = 0; n < 1300; )
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < 1300; k++, n++)
            begin
                logic [3:0] opc;
                // Mostly defined ops; unused codes now and then.
                opc = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                                  : 4'($urandom_range(0, 8));
                send(opc, pick_operand(), pick_operand());
            end
            if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 12));
            if (n > 600 && n < 650)
            begin
                idle(1);
                wait (sb.pending.size() == 0);
                @(negedge clk);
            end
        end
        idle(1);
        stim_done = 1'b1;
    end

    initial
    begin
        wait (stim_done);
        wait (sb.pending.size() == 0);
        repeat (PIPE_LAT + 10) @(posedge clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Worst case ~1330 items, each up to a long stall plus latency.
    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/cia_pkg.sv
rtl/cia_cell.sv
rtl/cia_finish.sv
rtl/checked_int64_alu.sv
rtl/cia_checker.sv
tb/checked_int64_alu_tb.sv
